// ===== hdl/swr_pkg.sv =====
`timescale 1ns / 1ps

package swr_pkg;

	localparam int TEMP_W   = 8;
	localparam int SENSOR_W = 3;
	localparam int COUNT_W  = 6;
	localparam int RANK_W   = 3;
	localparam int RANGE_W  = 8;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam int SENSORS_DEF    = 8;
	localparam int WINDOW_LEN_DEF = 10;
	localparam int TOP_K_DEF      = 5;

	// tdata / tuser layout
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 40;
	localparam int M_TUSER_W = 3;

	typedef logic signed [TEMP_W-1:0] temp_t;

	typedef struct packed {
		logic [RANGE_W-1:0]  max_range;
		logic [COUNT_W-1:0]  start;
		logic [SENSOR_W-1:0] sensor;
		logic                valid;
	} best_t;

endpackage

// ===== hdl/swr_topk.sv =====
`timescale 1ns / 1ps

// Sorted (descending) set of distinct values with a combinational insert.
module swr_topk #(
	parameter int TOP_K = swr_pkg::TOP_K_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         clear,
	input  swr_pkg::temp_t               value,
	output swr_pkg::temp_t               nxt_set [TOP_K],
	output logic [$clog2(TOP_K+1)-1:0]   nxt_cnt
);

	localparam int CNT_W = $clog2(TOP_K+1);

	swr_pkg::temp_t   set_q [TOP_K];
	logic [CNT_W-1:0] cnt_q;

	logic [TOP_K-1:0] gt;
	logic             dup;
	logic             insert;

	always_comb begin
		dup = 1'b0;
		for (int i = 0; i < TOP_K; i++) begin
			gt[i] = (CNT_W'(i) < cnt_q) && (set_q[i] > value);
			if ((CNT_W'(i) < cnt_q) && (set_q[i] == value))
				dup = 1'b1;
		end
		// gt is a prefix: the insert slot is the first entry not above value
		insert = !dup && !gt[TOP_K-1];
		for (int i = 0; i < TOP_K; i++) begin
			if (!insert || gt[i])
				nxt_set[i] = set_q[i];
			else if (i == 0)
				nxt_set[i] = value;
			else if (gt[i-1])
				nxt_set[i] = value;
			else
				nxt_set[i] = set_q[i-1];
		end
		if (insert && (cnt_q < CNT_W'(TOP_K)))
			nxt_cnt = cnt_q + CNT_W'(1);
		else
			nxt_cnt = cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			for (int i = 0; i < TOP_K; i++)
				set_q[i] <= '0;
		end else if (en) begin
			cnt_q <= clear ? '0 : nxt_cnt;
			for (int i = 0; i < TOP_K; i++)
				set_q[i] <= clear ? '0 : nxt_set[i];
		end
	end

endmodule

// ===== hdl/swr_window.sv =====
`timescale 1ns / 1ps

// Per-sensor reading windows, window range via min/max tree, best-range tracking.
module swr_window #(
	parameter int SENSORS    = swr_pkg::SENSORS_DEF,
	parameter int WINDOW_LEN = swr_pkg::WINDOW_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          clear,
	input  logic [swr_pkg::SENSOR_W-1:0]  sensor,
	input  swr_pkg::temp_t                temperature,
	output swr_pkg::best_t                best_nxt
);

	localparam int SIDX_W = (SENSORS > 1) ? $clog2(SENSORS) : 1;
	localparam int ROW_W  = WINDOW_LEN * swr_pkg::TEMP_W;
	localparam int LV     = $clog2(WINDOW_LEN);
	localparam int P      = 1 << LV;
	localparam int CW     = swr_pkg::COUNT_W;
	localparam int TW     = swr_pkg::TEMP_W;

	// newest reading in the low bits of each row
	logic [ROW_W-1:0] row_q [SENSORS];
	logic [CW-1:0]    cnt_q [SENSORS];
	swr_pkg::best_t   best_q;

	logic [SIDX_W-1:0] idx;
	logic              in_range;
	logic [ROW_W-1:0]  new_row;
	logic [CW-1:0]     cnt_nx;
	logic              full;
	swr_pkg::temp_t    mx_n [2*P-1];
	swr_pkg::temp_t    mn_n [2*P-1];
	logic signed [TW:0] diff;

	assign idx      = SIDX_W'(sensor);
	assign in_range = 32'(sensor) < SENSORS;

	always_comb begin
		new_row = {row_q[idx][ROW_W-TW-1:0], temperature};
		if (cnt_q[idx] < swr_pkg::COUNT_MAX)
			cnt_nx = cnt_q[idx] + CW'(1);
		else
			cnt_nx = cnt_q[idx];
		full = in_range && (cnt_nx >= CW'(WINDOW_LEN));
	end

	// balanced min/max tree, unused leaves padded with the newest reading
	always_comb begin
		for (int i = 0; i < P; i++) begin
			if (i < WINDOW_LEN) begin
				mx_n[P-1+i] = new_row[i*TW +: TW];
				mn_n[P-1+i] = new_row[i*TW +: TW];
			end else begin
				mx_n[P-1+i] = temperature;
				mn_n[P-1+i] = temperature;
			end
		end
		for (int j = P-2; j >= 0; j--) begin
			mx_n[j] = (mx_n[2*j+1] > mx_n[2*j+2]) ? mx_n[2*j+1] : mx_n[2*j+2];
			mn_n[j] = (mn_n[2*j+1] < mn_n[2*j+2]) ? mn_n[2*j+1] : mn_n[2*j+2];
		end
		diff = {mx_n[0][TW-1], mx_n[0]} - {mn_n[0][TW-1], mn_n[0]};
	end

	always_comb begin
		best_nxt = best_q;
		if (full && (!best_q.valid || (diff[TW-1:0] > best_q.max_range))) begin
			best_nxt.max_range = diff[TW-1:0];
			best_nxt.start     = cnt_nx - CW'(WINDOW_LEN);
			best_nxt.sensor    = sensor;
			best_nxt.valid     = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_range)
			row_q[idx] <= new_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
			for (int i = 0; i < SENSORS; i++)
				cnt_q[i] <= '0;
		end else if (en) begin
			best_q <= clear ? '0 : best_nxt;
			for (int i = 0; i < SENSORS; i++) begin
				if (clear)
					cnt_q[i] <= '0;
				else if (in_range && (idx == SIDX_W'(i)))
					cnt_q[i] <= cnt_nx;
			end
		end
	end

endmodule

// ===== hdl/swr_report.sv =====
`timescale 1ns / 1ps

// Holds one end-of-hour snapshot and plays it out as TOP_K transactions.
module swr_report #(
	parameter int TOP_K = swr_pkg::TOP_K_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  swr_pkg::temp_t                      high_set [TOP_K],
	input  logic [$clog2(TOP_K+1)-1:0]          high_cnt,
	input  swr_pkg::temp_t                      low_set [TOP_K],
	input  logic [$clog2(TOP_K+1)-1:0]          low_cnt,
	input  swr_pkg::best_t                      best,
	output logic                                busy,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// rank[2:0], high_temp[10:3], low_temp[18:11], max_range[26:19],
	// range_start[32:27], range_sensor[35:33], zero pad[39:36]
	output logic [swr_pkg::M_TDATA_W-1:0]       m_tdata,
	// high_valid[0], low_valid[1], range_valid[2]
	output logic [swr_pkg::M_TUSER_W-1:0]       m_tuser,
	output logic                                m_tlast
);

	localparam int CNT_W = $clog2(TOP_K+1);
	localparam int IDX_W = (TOP_K > 1) ? $clog2(TOP_K) : 1;
	localparam int RW    = swr_pkg::RANK_W;

	logic                     busy_q;
	logic [RW-1:0]            rank_q;
	swr_pkg::temp_t           high_q [TOP_K];
	swr_pkg::temp_t           low_q [TOP_K];
	logic [CNT_W-1:0]         hcnt_q;
	logic [CNT_W-1:0]         lcnt_q;
	swr_pkg::best_t           best_q;

	logic                     hv;
	logic                     lv;
	logic                     last;
	logic [CNT_W-1:0]         hidx;
	swr_pkg::temp_t           htemp;
	swr_pkg::temp_t           ltemp;

	always_comb begin
		hv    = CNT_W'(rank_q) < hcnt_q;
		lv    = CNT_W'(rank_q) < lcnt_q;
		last  = rank_q == RW'(TOP_K - 1);
		// highest set is held descending: walk it from the smallest valid entry
		hidx  = hcnt_q - CNT_W'(1) - CNT_W'(rank_q);
		htemp = hv ? high_q[hidx[IDX_W-1:0]] : '0;
		ltemp = lv ? low_q[rank_q[IDX_W-1:0]] : '0;
	end

	assign busy     = busy_q;
	assign m_tvalid = busy_q;
	assign m_tlast  = last;
	assign m_tuser  = {best_q.valid, lv, hv};
	assign m_tdata  = {4'b0, best_q.sensor, best_q.start, best_q.max_range,
			ltemp, htemp, rank_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rank_q <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			rank_q <= '0;
		end else if (busy_q && m_tready) begin
			if (last) begin
				busy_q <= 1'b0;
				rank_q <= '0;
			end else begin
				rank_q <= rank_q + RW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			hcnt_q <= high_cnt;
			lcnt_q <= low_cnt;
			best_q <= best;
			for (int i = 0; i < TOP_K; i++) begin
				high_q[i] <= high_set[i];
				// lowest set arrives as inverted values; inverted back, it is held ascending
				low_q[i]  <= ~low_set[i];
			end
		end
	end

endmodule

// ===== hdl/sensor_window_range_topk.sv =====
`timescale 1ns / 1ps

// Hourly sensor window range and top-k temperature report. Readings enter on
// the s_ side at up to one transaction per clock; each passes an input
// register and is then folded into the per-sensor window (range from a
// min/max tree over the last WINDOW_LEN readings), the best-range tracker
// and the highest/lowest distinct-value sets. A reading with tlast set (end
// of hour) takes a snapshot of all of that and clears the hour; the snapshot
// leaves on the m_ side as TOP_K transactions in ascending order, the final
// one with tlast. New readings keep flowing while a report drains; only a
// following end-of-hour reading waits in the input register until the
// previous report has sent its last transaction. While it waits, s_tready is
// low.
module sensor_window_range_topk #(
	parameter int SENSORS    = swr_pkg::SENSORS_DEF,
	parameter int WINDOW_LEN = swr_pkg::WINDOW_LEN_DEF,
	parameter int TOP_K      = swr_pkg::TOP_K_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// sensor[2:0], temperature[10:3], zero pad[15:11]
	input  logic [swr_pkg::S_TDATA_W-1:0]     s_tdata,
	// end_of_hour
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// rank[2:0], high_temp[10:3], low_temp[18:11], max_range[26:19],
	// range_start[32:27], range_sensor[35:33], zero pad[39:36]
	output logic [swr_pkg::M_TDATA_W-1:0]     m_tdata,
	// high_valid[0], low_valid[1], range_valid[2]
	output logic [swr_pkg::M_TUSER_W-1:0]     m_tuser,
	output logic                              m_tlast
);

	localparam int CNT_W = $clog2(TOP_K+1);
	localparam int SW    = swr_pkg::SENSOR_W;
	localparam int TW    = swr_pkg::TEMP_W;

	logic                 valid_s1;
	logic [SW-1:0]        sensor_s1;
	swr_pkg::temp_t       temp_s1;
	logic                 eoh_s1;

	logic                 busy;
	logic                 advance;
	logic                 clear;
	logic                 accept;

	swr_pkg::best_t       best_nxt;
	swr_pkg::temp_t       high_nxt [TOP_K];
	swr_pkg::temp_t       low_nxt [TOP_K];
	logic [CNT_W-1:0]     high_cnt;
	logic [CNT_W-1:0]     low_cnt;
	swr_pkg::temp_t       temp_inv;

	assign advance  = valid_s1 && !(eoh_s1 && busy);
	assign clear    = advance && eoh_s1;
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;
	// bitwise inversion reverses signed order, so the lowest set reuses the
	// descending insert
	assign temp_inv = ~temp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= accept || (valid_s1 && !advance);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sensor_s1 <= s_tdata[SW-1:0];
			temp_s1   <= s_tdata[SW +: TW];
			eoh_s1    <= s_tlast;
		end
	end

	swr_window #(
		.SENSORS    (SENSORS),
		.WINDOW_LEN (WINDOW_LEN)
	) u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (advance),
		.clear       (clear),
		.sensor      (sensor_s1),
		.temperature (temp_s1),
		.best_nxt    (best_nxt)
	);

	swr_topk #(
		.TOP_K (TOP_K)
	) u_high (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (advance),
		.clear   (clear),
		.value   (temp_s1),
		.nxt_set (high_nxt),
		.nxt_cnt (high_cnt)
	);

	swr_topk #(
		.TOP_K (TOP_K)
	) u_low (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (advance),
		.clear   (clear),
		.value   (temp_inv),
		.nxt_set (low_nxt),
		.nxt_cnt (low_cnt)
	);

	swr_report #(
		.TOP_K (TOP_K)
	) u_report (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (clear),
		.high_set (high_nxt),
		.high_cnt (high_cnt),
		.low_set  (low_nxt),
		.low_cnt  (low_cnt),
		.best     (best_nxt),
		.busy     (busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
